// File: rtl/core/jqfe_pkg.sv
// ----------------------------------------------------------------------------
// jqfe_pkg
// Types, constants and small decode functions shared by the JSON query field
// extractor.
// ----------------------------------------------------------------------------
package jqfe_pkg;

  localparam int unsigned KeyCapacity     = 64;
  localparam int unsigned IgnoredCapacity = 16;
  localparam int unsigned QueryCapacity   = 4096;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 12;
  localparam int unsigned KeyCntW = 7;
  localparam int unsigned KindW   = 2;
  localparam int unsigned TdataW  = 24;

  // Output queue: room for two beats from one byte plus slack for a stalled sink.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;
  localparam int unsigned QueueCntW  = 3;

  localparam logic [ByteW-1:0] ChLBrace    = 8'h7B;
  localparam logic [ByteW-1:0] ChRBrace    = 8'h7D;
  localparam logic [ByteW-1:0] ChColon     = 8'h3A;
  localparam logic [ByteW-1:0] ChComma     = 8'h2C;
  localparam logic [ByteW-1:0] ChQuote     = 8'h22;
  localparam logic [ByteW-1:0] ChBackslash = 8'h5C;
  localparam logic [ByteW-1:0] ChSlash     = 8'h2F;
  localparam logic [ByteW-1:0] ChLowerN    = 8'h6E;
  localparam logic [ByteW-1:0] ChLowerR    = 8'h72;
  localparam logic [ByteW-1:0] ChLowerT    = 8'h74;
  localparam logic [ByteW-1:0] ChNewline   = 8'h0A;
  localparam logic [ByteW-1:0] ChReturn    = 8'h0D;
  localparam logic [ByteW-1:0] ChTab       = 8'h09;
  localparam logic [ByteW-1:0] ChSpace     = 8'h20;

  localparam logic [KeyCntW-1:0] QueryKeyLen  = 7'd5;
  localparam logic [KeyCntW-1:0] KeyCountMax  = KeyCntW'(KeyCapacity - 1);
  localparam logic [LenW-1:0]    IgnoredMax   = LenW'(IgnoredCapacity - 1);
  localparam logic [LenW-1:0]    QueryCharMax = LenW'(QueryCapacity - 1);
  localparam logic [LenW-1:0]    MaxQueryRst  = 12'd4095;

  typedef enum logic [KindW-1:0] {
    KIND_CHAR   = 2'd0,
    KIND_FOUND  = 2'd1,
    KIND_FAILED = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    PH_LEAD   = 4'd0,
    PH_MEMBER = 4'd1,
    PH_KEY    = 4'd2,
    PH_KEYESC = 4'd3,
    PH_COLON  = 4'd4,
    PH_VALUE  = 4'd5,
    PH_ISTR   = 4'd6,
    PH_IESC   = 4'd7,
    PH_SKIP   = 4'd8,
    PH_AFTER  = 4'd9,
    PH_QSTR   = 4'd10,
    PH_QESC   = 4'd11
  } phase_e;

  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  query_char;
    logic [LenW-1:0]   query_length;
    logic              run_last;
  } result_t;

  typedef struct packed {
    logic             ok;
    logic [ByteW-1:0] ch;
  } escape_t;

  function automatic logic is_ws(input logic [ByteW-1:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChReturn));
  endfunction

  function automatic escape_t decode_escape(input logic [ByteW-1:0] c);
    escape_t e;
    e.ok = 1'b1;
    e.ch = c;
    if (c == ChLowerN) begin
      e.ch = ChNewline;
    end else if (c == ChLowerR) begin
      e.ch = ChReturn;
    end else if (c == ChLowerT) begin
      e.ch = ChTab;
    end else if (!((c == ChQuote) || (c == ChBackslash) || (c == ChSlash))) begin
      e.ok = 1'b0;
    end
    return e;
  endfunction

  // Characters of the key "query", by position.
  function automatic logic [ByteW-1:0] query_key_char(input logic [2:0] idx);
    logic [ByteW-1:0] c;
    case (idx)
      3'd0:    c = 8'h71;
      3'd1:    c = 8'h75;
      3'd2:    c = 8'h65;
      3'd3:    c = 8'h72;
      3'd4:    c = 8'h79;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/json_query_field_extractor.sv
// ----------------------------------------------------------------------------
// json_query_field_extractor
// Walks a JSON object byte by byte and streams the decoded string value of
// the member "query", followed by a found or failed verdict beat.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  s_axis   | in        | tdata[7:0] body_byte, tlast body_last
//  m_axis   | out       | tdata[7:0] query_char, [19:8] query_length,
//           |           | tuser[1:0] kind, tlast run_last
//  cfg      | in        | cfg_data_i max_query_chars, always ready
//
// One body byte is taken per clock while input ready is high. The parse state
// updates in the cycle a beat is accepted and its results land in a four-entry
// output queue; a byte that yields two results (a character plus failed on the
// last byte) writes two queue entries. Input ready drops while fewer than two
// queue slots are free. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module json_query_field_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] body_byte
  input  logic        s_axis_tlast_i,   // body_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] query_char, [19:8] query_length
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o,   // run_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [11:0] cfg_data_i        // max_query_chars
);

  jqfe_pkg::phase_e               phase_q, phase_d;
  logic                           match_q, match_d;
  logic [jqfe_pkg::KeyCntW-1:0]   key_count_q, key_count_d;
  logic [jqfe_pkg::LenW-1:0]      value_count_q, value_count_d;
  logic                           verdict_q, verdict_d;
  logic [jqfe_pkg::LenW-1:0]      max_query_q;

  logic                           in_fire;
  logic                           proc_fail, emit_char, emit_found, end_fail;
  logic [jqfe_pkg::ByteW-1:0]     char_val;
  logic [jqfe_pkg::ByteW-1:0]     b;
  jqfe_pkg::escape_t              esc;
  logic [jqfe_pkg::LenW-1:0]      limit;

  jqfe_pkg::result_t              res0, res1;
  logic [1:0]                     n_res;

  jqfe_pkg::result_t              queue_q [jqfe_pkg::QueueDepth];
  logic [jqfe_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [jqfe_pkg::QueueCntW-1:0] count_q;
  logic                           pop;
  jqfe_pkg::result_t              head;

  assign b           = s_axis_tdata_i;
  assign esc         = jqfe_pkg::decode_escape(b);
  assign limit       = (max_query_q > jqfe_pkg::QueryCharMax) ? jqfe_pkg::QueryCharMax
                                                               : max_query_q;
  assign cfg_ready_o = 1'b1;

  assign s_axis_tready_o = (count_q <= jqfe_pkg::QueueCntW'(jqfe_pkg::QueueDepth - 2));
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Next parse state and the events that one byte raises.
  always_comb begin
    phase_d       = phase_q;
    match_d       = match_q;
    key_count_d   = key_count_q;
    value_count_d = value_count_q;
    proc_fail     = 1'b0;
    emit_char     = 1'b0;
    emit_found    = 1'b0;
    char_val      = b;

    if (!verdict_q) begin
      case (phase_q)
        jqfe_pkg::PH_LEAD: begin
          if (!jqfe_pkg::is_ws(b)) begin
            if (b == jqfe_pkg::ChLBrace) phase_d = jqfe_pkg::PH_MEMBER;
            else proc_fail = 1'b1;
          end
        end
        jqfe_pkg::PH_MEMBER, jqfe_pkg::PH_AFTER: begin
          if (!jqfe_pkg::is_ws(b)) begin
            if (b == jqfe_pkg::ChQuote) begin
              phase_d     = jqfe_pkg::PH_KEY;
              key_count_d = '0;
              match_d     = 1'b1;
            end else if ((phase_q == jqfe_pkg::PH_AFTER) && (b == jqfe_pkg::ChComma)) begin
              phase_d = jqfe_pkg::PH_MEMBER;
            end else begin
              proc_fail = 1'b1;
            end
          end
        end
        jqfe_pkg::PH_KEY, jqfe_pkg::PH_KEYESC: begin
          if ((phase_q == jqfe_pkg::PH_KEY) && (b == jqfe_pkg::ChQuote)) begin
            match_d = match_q && (key_count_q == jqfe_pkg::QueryKeyLen);
            phase_d = jqfe_pkg::PH_COLON;
          end else if ((phase_q == jqfe_pkg::PH_KEY) && (b == jqfe_pkg::ChBackslash)) begin
            phase_d = jqfe_pkg::PH_KEYESC;
          end else if ((phase_q == jqfe_pkg::PH_KEYESC) && !esc.ok) begin
            proc_fail = 1'b1;
          end else if (key_count_q >= jqfe_pkg::KeyCountMax) begin
            proc_fail = 1'b1;
          end else begin
            char_val = (phase_q == jqfe_pkg::PH_KEYESC) ? esc.ch : b;
            if ((key_count_q >= jqfe_pkg::QueryKeyLen) ||
                (jqfe_pkg::query_key_char(key_count_q[2:0]) != char_val)) begin
              match_d = 1'b0;
            end
            key_count_d = key_count_q + 1'b1;
            phase_d     = jqfe_pkg::PH_KEY;
          end
        end
        jqfe_pkg::PH_COLON: begin
          if (!jqfe_pkg::is_ws(b)) begin
            if (b == jqfe_pkg::ChColon) phase_d = jqfe_pkg::PH_VALUE;
            else proc_fail = 1'b1;
          end
        end
        jqfe_pkg::PH_VALUE: begin
          if (!jqfe_pkg::is_ws(b)) begin
            if (match_q) begin
              if (b == jqfe_pkg::ChQuote) begin
                phase_d       = jqfe_pkg::PH_QSTR;
                value_count_d = '0;
              end else begin
                proc_fail = 1'b1;
              end
            end else if (b == jqfe_pkg::ChQuote) begin
              phase_d       = jqfe_pkg::PH_ISTR;
              value_count_d = '0;
            end else if (b == jqfe_pkg::ChComma) begin
              phase_d = jqfe_pkg::PH_MEMBER;
            end else if (b == jqfe_pkg::ChRBrace) begin
              proc_fail = 1'b1;
            end else begin
              phase_d = jqfe_pkg::PH_SKIP;
            end
          end
        end
        jqfe_pkg::PH_ISTR, jqfe_pkg::PH_IESC: begin
          if ((phase_q == jqfe_pkg::PH_ISTR) && (b == jqfe_pkg::ChQuote)) begin
            phase_d = jqfe_pkg::PH_AFTER;
          end else if ((phase_q == jqfe_pkg::PH_ISTR) && (b == jqfe_pkg::ChBackslash)) begin
            phase_d = jqfe_pkg::PH_IESC;
          end else if ((phase_q == jqfe_pkg::PH_IESC) && !esc.ok) begin
            proc_fail = 1'b1;
          end else if (value_count_q >= jqfe_pkg::IgnoredMax) begin
            proc_fail = 1'b1;
          end else begin
            value_count_d = value_count_q + 1'b1;
            phase_d       = jqfe_pkg::PH_ISTR;
          end
        end
        jqfe_pkg::PH_SKIP: begin
          if (b == jqfe_pkg::ChComma) phase_d = jqfe_pkg::PH_MEMBER;
          else if (b == jqfe_pkg::ChRBrace) proc_fail = 1'b1;
        end
        jqfe_pkg::PH_QSTR, jqfe_pkg::PH_QESC: begin
          if ((phase_q == jqfe_pkg::PH_QSTR) && (b == jqfe_pkg::ChQuote)) begin
            emit_found = 1'b1;
          end else if ((phase_q == jqfe_pkg::PH_QSTR) && (b == jqfe_pkg::ChBackslash)) begin
            phase_d = jqfe_pkg::PH_QESC;
          end else if ((phase_q == jqfe_pkg::PH_QESC) && !esc.ok) begin
            proc_fail = 1'b1;
          end else if (value_count_q >= limit) begin
            proc_fail = 1'b1;
          end else begin
            char_val      = (phase_q == jqfe_pkg::PH_QESC) ? esc.ch : b;
            emit_char     = 1'b1;
            value_count_d = value_count_q + 1'b1;
            phase_d       = jqfe_pkg::PH_QSTR;
          end
        end
        default: begin
          proc_fail = 1'b1;
        end
      endcase
    end

    verdict_d = verdict_q || proc_fail || emit_found;
    end_fail  = s_axis_tlast_i && !verdict_d;

    // The last byte of a body returns the parser to its reset state.
    if (s_axis_tlast_i) begin
      phase_d   = jqfe_pkg::PH_LEAD;
      match_d   = 1'b1;
      verdict_d = 1'b0;
    end
  end

  // Result beats for the accepted byte, in order.
  always_comb begin
    logic [jqfe_pkg::LenW-1:0] sent_len;
    sent_len = ((phase_d == jqfe_pkg::PH_QSTR) || (phase_d == jqfe_pkg::PH_QESC) ||
                emit_found || s_axis_tlast_i) ? value_count_d : '0;
    // On the last byte phase_d has already been rewound, so decide from the
    // phase the byte left behind.
    if (s_axis_tlast_i) begin
      sent_len = ((phase_q == jqfe_pkg::PH_QSTR) || (phase_q == jqfe_pkg::PH_QESC))
                 ? value_count_d : '0;
    end

    res0.kind         = jqfe_pkg::KIND_CHAR;
    res0.query_char   = '0;
    res0.query_length = '0;
    res0.run_last     = 1'b1;
    res1              = res0;
    res1.kind         = jqfe_pkg::KIND_FAILED;
    res1.query_length = sent_len;
    n_res             = 2'd0;

    if (emit_char) begin
      res0.query_char = char_val;
      res0.run_last   = !end_fail;
      n_res           = end_fail ? 2'd2 : 2'd1;
    end else if (emit_found) begin
      res0.kind         = jqfe_pkg::KIND_FOUND;
      res0.query_length = value_count_q;
      n_res             = 2'd1;
    end else if (proc_fail || end_fail) begin
      res0.kind         = jqfe_pkg::KIND_FAILED;
      res0.query_length = sent_len;
      n_res             = 2'd1;
    end
  end

  // The last byte of a body clears both counters along with the phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= jqfe_pkg::PH_LEAD;
      match_q       <= 1'b1;
      key_count_q   <= '0;
      value_count_q <= '0;
      verdict_q     <= 1'b0;
      max_query_q   <= jqfe_pkg::MaxQueryRst;
    end else begin
      if (in_fire) begin
        phase_q       <= phase_d;
        match_q       <= match_d;
        key_count_q   <= s_axis_tlast_i ? '0 : key_count_d;
        value_count_q <= s_axis_tlast_i ? '0 : value_count_d;
        verdict_q     <= verdict_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        max_query_q <= cfg_data_i;
      end
    end
  end

  assign head            = queue_q[rd_ptr_q];
  assign m_axis_tvalid_o = (count_q != '0);
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;
  assign m_axis_tdata_o  = {4'b0, head.query_length, head.query_char};
  assign m_axis_tuser_o  = head.kind;
  assign m_axis_tlast_o  = head.run_last;

  always_ff @(posedge clk_i) begin
    if (in_fire && (n_res != 2'd0)) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (in_fire && (n_res == 2'd2)) begin
      queue_q[wr_ptr_q + jqfe_pkg::QueuePtrW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + jqfe_pkg::QueuePtrW'(n_res);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + jqfe_pkg::QueuePtrW'(1);
      end
      count_q <= count_q + (in_fire ? jqfe_pkg::QueueCntW'(n_res) : '0)
                 - jqfe_pkg::QueueCntW'(pop);
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JSON query field extractor. Body bytes are fed
// as short JSON objects with random keys, values, escapes and faults, plus
// pure noise. A tracker class mirrors the parser, queues the beats each
// accepted byte should cause and checks every output beat against them.
// Source and sink stall at random, and the sink holds off once for long.
// ----------------------------------------------------------------------------
module tb_top;
  import jqfe_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseBytes  = 300;

  class query_tracker;
    result_t         pending_beats[$];
    result_t         step_beats[$];
    logic [LenW-1:0] max_chars;
    phase_e          ph;
    bit              key_hit;
    int unsigned     key_len;
    int unsigned     val_len;
    bit              verdict_done;
    int unsigned     errors;
    string           query_key;

    function new();
      query_key = "query";
      errors    = 0;
      max_chars = MaxQueryRst;
      restart_body();
    endfunction

    function void restart_body();
      ph           = PH_LEAD;
      key_hit      = 1'b1;
      key_len      = 0;
      val_len      = 0;
      verdict_done = 1'b0;
    endfunction

    function bit is_space(logic [7:0] c);
      return (c == ChSpace) || ((c >= ChTab) && (c <= ChReturn));
    endfunction

    // Decoded byte of an escape; bit 8 is set when the escape is not allowed.
    function logic [8:0] unescape(logic [7:0] c);
      case (c)
        ChQuote, ChBackslash, ChSlash: return {1'b0, c};
        ChLowerN: return {1'b0, ChNewline};
        ChLowerR: return {1'b0, ChReturn};
        ChLowerT: return {1'b0, ChTab};
        default:  return 9'h100;
      endcase
    endfunction

    function void emit(kind_e k, logic [7:0] c, int unsigned len);
      result_t r;
      r.kind         = k;
      r.query_char   = c;
      r.query_length = LenW'(len);
      r.run_last     = 1'b0;
      step_beats.push_back(r);
    endfunction

    // The count is only reported once the query value has started.
    function void fail_body();
      emit(KIND_FAILED, 8'h00, ((ph == PH_QSTR) || (ph == PH_QESC)) ? val_len : 0);
      verdict_done = 1'b1;
    endfunction

    function void start_key();
      ph      = PH_KEY;
      key_len = 0;
      key_hit = 1'b1;
    endfunction

    function void key_char(logic [7:0] c);
      if (key_len >= KeyCapacity - 1) begin
        fail_body();
        return;
      end
      if ((key_len >= 5) || (query_key[key_len] != c)) key_hit = 1'b0;
      key_len++;
      ph = PH_KEY;
    endfunction

    function void ignored_char();
      if (val_len >= IgnoredCapacity - 1) begin
        fail_body();
        return;
      end
      val_len++;
      ph = PH_ISTR;
    endfunction

    function void query_char(logic [7:0] c);
      int unsigned cap;
      cap = (max_chars > QueryCapacity - 1) ? QueryCapacity - 1 : max_chars;
      if (val_len >= cap) begin
        fail_body();
        return;
      end
      emit(KIND_CHAR, c, 0);
      val_len++;
      ph = PH_QSTR;
    endfunction

    function void parse(logic [7:0] b);
      logic [8:0] esc;
      case (ph)
        PH_LEAD: begin
          if (!is_space(b)) begin
            if (b == ChLBrace) ph = PH_MEMBER;
            else fail_body();
          end
        end
        PH_MEMBER: begin
          if (!is_space(b)) begin
            if (b == ChQuote) start_key();
            else fail_body();
          end
        end
        PH_KEY: begin
          if (b == ChQuote) begin
            key_hit = key_hit && (key_len == 5);
            ph      = PH_COLON;
          end else if (b == ChBackslash) begin
            ph = PH_KEYESC;
          end else begin
            key_char(b);
          end
        end
        PH_KEYESC: begin
          esc = unescape(b);
          if (esc[8]) fail_body();
          else key_char(esc[7:0]);
        end
        PH_COLON: begin
          if (!is_space(b)) begin
            if (b == ChColon) ph = PH_VALUE;
            else fail_body();
          end
        end
        PH_VALUE: begin
          if (!is_space(b)) begin
            if (key_hit) begin
              if (b == ChQuote) begin
                ph      = PH_QSTR;
                val_len = 0;
              end else begin
                fail_body();
              end
            end else if (b == ChQuote) begin
              ph      = PH_ISTR;
              val_len = 0;
            end else if (b == ChComma) begin
              ph = PH_MEMBER;
            end else if (b == ChRBrace) begin
              fail_body();
            end else begin
              ph = PH_SKIP;
            end
          end
        end
        PH_ISTR: begin
          if (b == ChQuote) ph = PH_AFTER;
          else if (b == ChBackslash) ph = PH_IESC;
          else ignored_char();
        end
        PH_IESC: begin
          esc = unescape(b);
          if (esc[8]) fail_body();
          else ignored_char();
        end
        PH_SKIP: begin
          if (b == ChComma) ph = PH_MEMBER;
          else if (b == ChRBrace) fail_body();
        end
        PH_AFTER: begin
          if (!is_space(b)) begin
            if (b == ChComma) ph = PH_MEMBER;
            else if (b == ChQuote) start_key();
            else fail_body();
          end
        end
        PH_QSTR: begin
          if (b == ChQuote) begin
            emit(KIND_FOUND, 8'h00, val_len);
            verdict_done = 1'b1;
          end else if (b == ChBackslash) begin
            ph = PH_QESC;
          end else begin
            query_char(b);
          end
        end
        PH_QESC: begin
          esc = unescape(b);
          if (esc[8]) fail_body();
          else query_char(esc[7:0]);
        end
        default: fail_body();
      endcase
    endfunction

    function void take_body_byte(logic [7:0] b, bit last);
      step_beats.delete();
      if (!verdict_done) parse(b);
      if (last) begin
        if (!verdict_done) fail_body();
        restart_body();
      end
      if (step_beats.size() > 0) step_beats[step_beats.size() - 1].run_last = 1'b1;
      foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
    endfunction

    function void compare_beat(result_t got);
      result_t want;
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat: kind %0d, query_char %0h", got.kind, got.query_char);
        errors++;
        return;
      end
      want = pending_beats.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.query_char !== want.query_char) begin
        $error("query_char: expected %0h, got %0h", want.query_char, got.query_char);
        errors++;
      end
      if (got.query_length !== want.query_length) begin
        $error("query_length: expected %0d, got %0d", want.query_length, got.query_length);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = 8'h00;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TdataW-1:0] m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              m_axis_tlast;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [11:0]       cfg_data = 12'h000;

  query_tracker tracker;
  logic [7:0]   body_q[$];
  logic [7:0]   esc_pick[6] = '{ChQuote, ChBackslash, ChSlash, ChLowerN, ChLowerR, ChLowerT};
  bit           tx_idle_on = 1'b1;
  bit           rx_idle_on = 1'b1;
  bit           hold_off_req = 1'b0;
  int unsigned  sent_bytes = 0;
  int unsigned  cycle_count = 0;

  json_query_field_extractor i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL json_query_field_extractor");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    result_t beat;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beat.kind         = kind_e'(m_axis_tuser);
      beat.query_char   = m_axis_tdata[7:0];
      beat.query_length = m_axis_tdata[19:8];
      beat.run_last     = m_axis_tlast;
      tracker.compare_beat(beat);
    end
  end

  // Sink: short random stalls, plus one long hold-off on request.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = 299;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_on && ($urandom_range(0, 4) == 0)) begin
        stall_left = $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic put_byte(input logic [7:0] b, input bit last);
    int unsigned gap;
    if (tx_idle_on && ($urandom_range(0, 5) == 0)) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_body_byte(b, last);
    sent_bytes++;
  endtask

  task automatic send_body();
    foreach (body_q[i]) put_byte(body_q[i], i == body_q.size() - 1);
  endtask

  // A byte may cause no beat, so after the expected beats DrainCycles clocks pass.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_max_chars(input logic [11:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    tracker.max_chars = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endfunction

  function automatic void add_ws();
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        body_q.push_back(($urandom_range(0, 2) == 0) ? ChSpace : 8'($urandom_range(9, 13)));
      end
    end
  endfunction

  // Adds n decoded characters; now and then an escape that may be invalid.
  function automatic void add_text(int unsigned n);
    int unsigned r;
    logic [7:0]  c;
    repeat (n) begin
      r = $urandom_range(0, 63);
      if (r < 6) begin
        body_q.push_back(ChBackslash);
        body_q.push_back(esc_pick[r]);
      end else if (r == 6) begin
        body_q.push_back(ChBackslash);
        body_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        c = (r < 15) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(8'h20, 8'h7E));
        if ((c == ChQuote) || (c == ChBackslash)) body_q.push_back(ChBackslash);
        body_q.push_back(c);
      end
    end
  endfunction

  function automatic void add_member();
    int unsigned r;
    r = $urandom_range(0, 9);
    add_ws();
    body_q.push_back(ChQuote);
    if (r == 0) push_str("quer");
    else if (r == 1) push_str("queryy");
    else if (r == 2) add_text($urandom_range(60, 64));
    else add_text($urandom_range(0, 8));
    body_q.push_back(ChQuote);
    add_ws();
    body_q.push_back(ChColon);
    add_ws();
    r = $urandom_range(0, 9);
    if (r < 6) begin
      body_q.push_back(ChQuote);
      add_text((r == 0) ? $urandom_range(14, 16) : $urandom_range(0, 8));
      body_q.push_back(ChQuote);
      add_ws();
      // Leaving out the comma after a string value is tolerated.
      if ($urandom_range(0, 4) != 0) body_q.push_back(ChComma);
    end else if (r < 9) begin
      repeat ($urandom_range(1, 4)) body_q.push_back(8'($urandom_range(8'h30, 8'h39)));
      add_ws();
      body_q.push_back(ChComma);
    end else begin
      body_q.push_back(ChRBrace);
    end
  endfunction

  function automatic void add_query_member();
    int unsigned len;
    add_ws();
    body_q.push_back(ChQuote);
    push_str("query");
    body_q.push_back(ChQuote);
    add_ws();
    body_q.push_back(ChColon);
    add_ws();
    if ($urandom_range(0, 9) == 0) begin
      body_q.push_back(8'($urandom_range(8'h30, 8'h39)));
      return;
    end
    if ((tracker.max_chars <= 40) && ($urandom_range(0, 2) == 0)) begin
      len = tracker.max_chars + $urandom_range(0, 2);
      if (len > 0) len--;
    end else begin
      len = $urandom_range(0, 10);
    end
    body_q.push_back(ChQuote);
    add_text(len);
    body_q.push_back(ChQuote);
    add_ws();
    body_q.push_back(ChRBrace);
  endfunction

  function automatic void build_body();
    int unsigned cut;
    body_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) body_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    add_ws();
    body_q.push_back(ChLBrace);
    repeat ($urandom_range(0, 3)) add_member();
    if ($urandom_range(0, 7) == 0) begin
      add_ws();
      body_q.push_back(ChRBrace);
    end else begin
      add_query_member();
    end
    repeat ($urandom_range(0, 3)) body_q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) == 0) begin
      body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, body_q.size());
      while (body_q.size() > cut) void'(body_q.pop_back());
    end
  endfunction

  initial begin
    logic [11:0] limits[5];
    int unsigned target;
    tracker = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Found with an escape and a high byte, then a byte ignored after it.
    body_q.delete();
    push_str("{\"query\":\"\\n");
    body_q.push_back(8'hFF);
    push_str("\"x");
    send_body();
    // Closing brace where a member is expected.
    body_q.delete();
    push_str("{}");
    send_body();
    // A lone byte that is no brace.
    body_q.delete();
    body_q.push_back(8'hFF);
    send_body();
    // Body ends inside the query value: a character and the failure together.
    body_q.delete();
    push_str("{\"query\":\"ab");
    send_body();
    // A zero byte inside a key.
    body_q.delete();
    push_str("{\"");
    body_q.push_back(8'h00);
    send_body();
    settle();

    limits = '{12'd0, 12'd1, 12'd7, 12'($urandom_range(2, 40)), 12'd4095};
    foreach (limits[p]) begin
      write_max_chars(limits[p]);
      target = sent_bytes + PhaseBytes;
      if (p == 4) begin
        // Long query value while the sink holds off, so the input backs up.
        hold_off_req = 1'b1;
        body_q.delete();
        push_str("{\"query\":\"");
        add_text(40);
        push_str("\"}");
        send_body();
      end
      while (sent_bytes < target) begin
        if ((p == 4) && (sent_bytes + PhaseBytes / 2 > target)) begin
          tx_idle_on = 1'b0;
          rx_idle_on = 1'b0;
        end
        build_body();
        send_body();
      end
      settle();
    end

    if (tracker.errors == 0) begin
      $display("PASS json_query_field_extractor");
    end else begin
      $display("FAIL json_query_field_extractor");
    end
    $finish;
  end

endmodule

// File: json_query_field_extractor.f
rtl/core/jqfe_pkg.sv
rtl/core/json_query_field_extractor.sv
test/tb_top.sv
